// ===== rtl/i2cm_pkg.sv =====
// Shared payload types and command codes of the I2C register-access master.
package i2cm_pkg;

    localparam int unsigned TICKS_W = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] wr_byte;
        logic       wr_valid;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       wr_request;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

endpackage

// ===== rtl/i2cm_seq.sv =====
// Bus phase sequencer: holds the transaction state and builds one result per tick.
module i2cm_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  i2cm_pkg::t_in_item             i_item,
    input  logic [i2cm_pkg::TICKS_W-1:0]   i_phase_ticks,
    output i2cm_pkg::t_out_item            o_result
);
    import i2cm_pkg::*;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST1  = 5'd1;
    localparam logic [4:0] PH_ST2  = 5'd2;
    localparam logic [4:0] PH_ST3  = 5'd3;
    localparam logic [4:0] PH_TX1  = 5'd4;
    localparam logic [4:0] PH_TX2  = 5'd5;
    localparam logic [4:0] PH_TX3  = 5'd6;
    localparam logic [4:0] PH_AK1  = 5'd7;
    localparam logic [4:0] PH_AK2  = 5'd8;
    localparam logic [4:0] PH_AK3  = 5'd9;
    localparam logic [4:0] PH_RX1  = 5'd10;
    localparam logic [4:0] PH_RX2  = 5'd11;
    localparam logic [4:0] PH_MA1  = 5'd12;
    localparam logic [4:0] PH_MA2  = 5'd13;
    localparam logic [4:0] PH_MA3  = 5'd14;
    localparam logic [4:0] PH_MA4  = 5'd15;
    localparam logic [4:0] PH_SP1  = 5'd16;
    localparam logic [4:0] PH_SP2  = 5'd17;
    localparam logic [4:0] PH_SP3  = 5'd18;
    localparam logic [4:0] PH_SP4  = 5'd19;
    localparam logic [4:0] PH_WAIT = 5'd20;

    localparam logic [1:0] SG_ADDR_W = 2'd0;
    localparam logic [1:0] SG_REG    = 2'd1;
    localparam logic [1:0] SG_ADDR_R = 2'd2;
    localparam logic [1:0] SG_DATA_W = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_START_FAIL = 2'd1;
    localparam logic [1:0] ST_ADDR_NACK  = 2'd2;
    localparam logic [1:0] ST_DATA_NACK  = 2'd3;

    logic [4:0]         r_phase, n_phase;
    logic [TICKS_W-1:0] r_timer, n_timer;
    logic [3:0]         r_bit, n_bit;
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_bytes, n_bytes;
    logic [6:0]         r_target, n_target;
    logic [7:0]         r_regaddr, n_regaddr;
    logic               r_is_read, n_is_read;
    logic [1:0]         r_status, n_status;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic [1:0]         r_stage, n_stage;

    logic [TICKS_W-1:0] timer_inc;
    logic [TICKS_W-1:0] phase_len;
    logic               expired;
    logic               first_start;
    logic               enter_en;
    logic [7:0]         rd_byte;
    logic               rd_valid;
    logic               rd_last;
    logic               done;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        n_target  = r_target;
        n_regaddr = r_regaddr;
        n_is_read = r_is_read;
        n_status  = r_status;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_stage   = r_stage;
        enter_en  = 1'b0;
        rd_byte   = 8'd0;
        rd_valid  = 1'b0;
        rd_last   = 1'b0;
        done      = 1'b0;

        timer_inc   = r_timer + 1'b1;
        phase_len   = (i_phase_ticks == '0) ? TICKS_W'(1) : i_phase_ticks;
        expired     = (timer_inc >= phase_len);
        first_start = (r_stage == SG_ADDR_W);

        case (r_phase)
            PH_IDLE: begin
                if (i_item.op inside {OP_WRITE, OP_READ}) begin
                    n_target  = i_item.dev_addr;
                    n_regaddr = i_item.reg_addr;
                    n_bytes   = i_item.byte_count;
                    n_is_read = (i_item.op == OP_READ);
                    n_status  = ST_OK;
                    n_stage   = SG_ADDR_W;
                    n_phase   = PH_ST1;
                    enter_en  = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_item.wr_valid) begin
                    n_shift  = i_item.wr_byte;
                    n_bit    = 4'd0;
                    n_phase  = PH_TX1;
                    enter_en = 1'b1;
                end
            end
            default: begin
                n_timer = timer_inc;
                if (expired) begin
                    enter_en = 1'b1;
                    case (r_phase)
                        PH_ST1: begin
                            if (first_start && !i_item.sda_in) begin
                                n_status = ST_START_FAIL;
                                n_phase  = PH_IDLE;
                                done     = 1'b1;
                                enter_en = 1'b0;
                            end else begin
                                n_phase = PH_ST2;
                            end
                        end
                        PH_ST2: begin
                            if (first_start && i_item.sda_in) begin
                                n_status = ST_START_FAIL;
                                n_phase  = PH_IDLE;
                                done     = 1'b1;
                                enter_en = 1'b0;
                            end else begin
                                n_phase = PH_ST3;
                            end
                        end
                        PH_ST3: begin
                            n_shift = {r_target, (r_stage == SG_ADDR_R)};
                            n_bit   = 4'd0;
                            n_phase = PH_TX1;
                        end
                        PH_TX1: n_phase = PH_TX2;
                        PH_TX2: n_phase = PH_TX3;
                        PH_TX3: begin
                            n_bit   = r_bit + 1'b1;
                            n_phase = n_bit[3] ? PH_AK1 : PH_TX1;
                        end
                        PH_AK1: n_phase = PH_AK2;
                        PH_AK2: n_phase = PH_AK3;
                        PH_AK3: begin
                            n_scl = 1'b0;
                            case (r_stage)
                                SG_ADDR_W: begin
                                    if (i_item.sda_in) begin
                                        n_status = ST_ADDR_NACK;
                                        n_phase  = PH_SP1;
                                    end else begin
                                        n_stage = SG_REG;
                                        n_shift = r_regaddr;
                                        n_bit   = 4'd0;
                                        n_phase = PH_TX1;
                                    end
                                end
                                SG_REG: begin
                                    if (r_is_read) begin
                                        n_stage = SG_ADDR_R;
                                        n_phase = PH_ST1;
                                    end else begin
                                        n_stage = SG_DATA_W;
                                        if (r_bytes == 8'd0) begin
                                            n_phase = PH_SP1;
                                        end else begin
                                            n_phase  = PH_WAIT;
                                            enter_en = 1'b0;
                                        end
                                    end
                                end
                                SG_ADDR_R: begin
                                    if (r_bytes == 8'd0) begin
                                        n_phase = PH_SP1;
                                    end else begin
                                        n_sda   = 1'b1;
                                        n_shift = 8'd0;
                                        n_bit   = 4'd0;
                                        n_phase = PH_RX1;
                                    end
                                end
                                default: begin
                                    if (i_item.sda_in) begin
                                        n_status = ST_DATA_NACK;
                                        n_phase  = PH_SP1;
                                    end else begin
                                        n_bytes = r_bytes - 1'b1;
                                        if (n_bytes == 8'd0) begin
                                            n_phase = PH_SP1;
                                        end else begin
                                            n_phase  = PH_WAIT;
                                            enter_en = 1'b0;
                                        end
                                    end
                                end
                            endcase
                        end
                        PH_RX1: n_phase = PH_RX2;
                        PH_RX2: begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_bit   = r_bit + 1'b1;
                            if (n_bit[3]) begin
                                rd_byte  = n_shift;
                                rd_valid = 1'b1;
                                rd_last  = (r_bytes == 8'd1);
                                n_phase  = PH_MA1;
                            end else begin
                                n_phase = PH_RX1;
                            end
                        end
                        PH_MA1: n_phase = PH_MA2;
                        PH_MA2: n_phase = PH_MA3;
                        PH_MA3: n_phase = PH_MA4;
                        PH_MA4: begin
                            n_bytes = r_bytes - 1'b1;
                            if (n_bytes == 8'd0) begin
                                n_phase = PH_SP1;
                            end else begin
                                n_sda   = 1'b1;
                                n_shift = 8'd0;
                                n_bit   = 4'd0;
                                n_phase = PH_RX1;
                            end
                        end
                        PH_SP1: n_phase = PH_SP2;
                        PH_SP2: n_phase = PH_SP3;
                        PH_SP3: n_phase = PH_SP4;
                        PH_SP4: begin
                            n_phase  = PH_IDLE;
                            done     = 1'b1;
                            enter_en = 1'b0;
                        end
                        default: begin
                            n_phase  = PH_IDLE;
                            enter_en = 1'b0;
                        end
                    endcase
                end
            end
        endcase

        // Apply the line levels that belong to the phase being entered.
        if (enter_en) begin
            n_timer = '0;
            case (n_phase)
                PH_ST1: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                end
                PH_ST2, PH_ST3, PH_SP2: n_sda = 1'b0;
                PH_TX2: begin
                    n_sda   = n_shift[7];
                    n_shift = {n_shift[6:0], 1'b0};
                end
                PH_AK2, PH_SP4: n_sda = 1'b1;
                PH_MA2: n_sda = (n_bytes == 8'd1);
                PH_TX3, PH_AK3, PH_RX2, PH_MA3, PH_SP3: n_scl = 1'b1;
                PH_TX1, PH_AK1, PH_RX1, PH_MA1, PH_MA4, PH_SP1: n_scl = 1'b0;
                default: ;
            endcase
        end

        o_result.scl_out    = n_scl;
        o_result.sda_out    = n_sda;
        o_result.rd_byte    = rd_byte;
        o_result.rd_valid   = rd_valid;
        o_result.rd_last    = rd_last;
        o_result.wr_request = (n_phase == PH_WAIT);
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.status     = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_bit     <= 4'd0;
            r_shift   <= 8'd0;
            r_bytes   <= 8'd0;
            r_target  <= 7'd0;
            r_regaddr <= 8'd0;
            r_is_read <= 1'b0;
            r_status  <= ST_OK;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_stage   <= SG_ADDR_W;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_target  <= n_target;
            r_regaddr <= n_regaddr;
            r_is_read <= n_is_read;
            r_status  <= n_status;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_stage   <= n_stage;
        end
    end

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// Top level of the I2C register-access master: handshake registers and configuration.
//
// I2C master that runs one register transaction per command: a burst write
// (start, device address, register byte, data bytes, stop) or a burst read
// (start, device address, register byte, repeated start, device address with
// the read bit, received bytes, stop). Every input transaction is one tick of
// the bus timing; it carries the command fields, the next write byte and the
// sampled SDA level, and it produces exactly one output transaction with the
// SCL/SDA levels to drive and the status of the bus work. One tick is taken
// every clock cycle while the result register is free or drains; a tick passes
// through the input register and then the result register around the
// single-pass phase sequencer. Each bus phase lasts phase_ticks ticks (a written
// value of zero counts as one). Write the configuration register only while no
// transaction is in progress; it takes effect on the next tick.
module i2c_master_register_access (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  i2cm_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output i2cm_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2cm_pkg::TICKS_W-1:0]   i_cfg_data
);
    import i2cm_pkg::*;

    t_in_item            r_in;
    logic                r_in_valid;
    t_out_item           r_out;
    logic                r_out_valid;
    logic [TICKS_W-1:0]  r_phase_ticks;

    t_out_item           seq_result;
    logic                step;
    logic                in_accept;

    // Advance a held tick whenever the result register is free or drains now.
    assign step      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept = i_in_valid && !o_in_stall;

    // The register is to be written only while idle; the block does not enforce this, so accept every write at once.
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (seq_result)
    );

    // Input register: hold the tick until the sequencer consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    // Result register: load on each step, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seq_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= TICKS_W'(7);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

`ifndef SYNTH
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("done raised while still busy");

    a_rd_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rd_valid) |-> o_out_item.busy_res)
        else $error("read byte delivered outside a transaction");

    a_wait_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.wr_request)
            |-> (o_out_item.busy_res && !o_out_item.scl_out))
        else $error("write request without SCL held low");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_phase_ticks == $past(i_cfg_data)))
        else $error("phase_ticks write lost");
`endif

endmodule
